### hdl/dmts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmts_pkg
// Shared types and field widths for the deadline-monotonic tick scheduler.
// ----------------------------------------------------------------------------
package dmts_pkg;

    localparam int CMD_W     = 2;
    localparam int IN_SLOT_W = 3;
    localparam int FIELD_W   = 16;
    localparam int ID_W      = 8;
    localparam int CFG_W     = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_TICK    = 2'd2
    } t_cmd;

endpackage

### hdl/dmts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmts_cell
// One task slot: holds the slot's parameters, remaining budget and phase, and
// updates the best-candidate token as it passes through on its way down.
// ----------------------------------------------------------------------------
module dmts_cell import dmts_pkg::*; #(
    parameter int TICK_WIDTH = 16,
    parameter int SLOT_W     = 3,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_active,
    input  logic                  i_load,
    input  logic                  i_restart,
    input  logic [TICK_WIDTH-1:0] i_budget,
    input  logic [TICK_WIDTH-1:0] i_period,
    input  logic [TICK_WIDTH-1:0] i_deadline,
    input  logic [ID_W-1:0]       i_task_id,
    input  logic                  i_tok_vld,
    input  logic                  i_tok_found,
    input  logic [TICK_WIDTH-1:0] i_tok_deadline,
    input  logic [SLOT_W-1:0]     i_tok_slot,
    input  logic [ID_W-1:0]       i_tok_id,
    output logic                  o_tok_vld,
    output logic                  o_tok_found,
    output logic [TICK_WIDTH-1:0] o_tok_deadline,
    output logic [SLOT_W-1:0]     o_tok_slot,
    output logic [ID_W-1:0]       o_tok_id,
    input  logic                  i_fin,
    input  logic                  i_fin_found,
    input  logic [SLOT_W-1:0]     i_fin_slot
);

    logic [TICK_WIDTH-1:0] r_budget;
    logic [TICK_WIDTH-1:0] r_period;
    logic [TICK_WIDTH-1:0] r_deadline;
    logic [ID_W-1:0]       r_id;
    logic [TICK_WIDTH-1:0] r_remaining;
    logic [TICK_WIDTH-1:0] n_remaining;
    logic [TICK_WIDTH-1:0] r_phase;
    logic [TICK_WIDTH-1:0] n_phase;
    logic                  r_tok_vld;
    logic                  r_tok_found;
    logic [TICK_WIDTH-1:0] r_tok_deadline;
    logic [SLOT_W-1:0]     r_tok_slot;
    logic [ID_W-1:0]       r_tok_id;

    logic                  w_visit;
    logic                  w_release;
    logic [TICK_WIDTH-1:0] w_rem_eff;
    logic                  w_take;
    logic [TICK_WIDTH:0]   w_phase_inc;
    logic                  w_picked;

    assign w_visit     = i_tok_vld && i_active;
    assign w_release   = (r_phase == '0);
    assign w_rem_eff   = w_release ? r_budget : r_remaining;
    assign w_take      = w_visit && (w_rem_eff != '0) &&
                         (!i_tok_found || (r_deadline < i_tok_deadline));
    assign w_phase_inc = {1'b0, r_phase} + (TICK_WIDTH+1)'(1);
    assign w_picked    = i_fin && i_fin_found && (i_fin_slot == SLOT_W'(IDX));

    always_comb begin
        n_remaining = r_remaining;
        if (i_restart) begin
            n_remaining = r_budget;
        end else if (w_visit && w_release) begin
            n_remaining = r_budget;
        end else if (w_picked) begin
            n_remaining = r_remaining - TICK_WIDTH'(1);
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (i_restart) begin
            n_phase = '0;
        end else if (i_fin && i_active) begin
            if (w_phase_inc >= {1'b0, r_period}) begin
                n_phase = '0;
            end else begin
                n_phase = w_phase_inc[TICK_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_budget   <= i_budget;
            r_period   <= i_period;
            r_deadline <= i_deadline;
            r_id       <= i_task_id;
        end
        r_tok_found    <= i_tok_found || w_take;
        r_tok_deadline <= w_take ? r_deadline : i_tok_deadline;
        r_tok_slot     <= w_take ? SLOT_W'(IDX) : i_tok_slot;
        r_tok_id       <= w_take ? r_id : i_tok_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_phase     <= '0;
            r_tok_vld   <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_phase     <= n_phase;
            r_tok_vld   <= i_tok_vld;
        end
    end

    assign o_tok_vld      = r_tok_vld;
    assign o_tok_found    = r_tok_found;
    assign o_tok_deadline = r_tok_deadline;
    assign o_tok_slot     = r_tok_slot;
    assign o_tok_id       = r_tok_id;

endmodule

### hdl/deadline_monotonic_tick_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_monotonic_tick_scheduler
// Periodic task scheduler: picks the released task with the shortest deadline.
// ----------------------------------------------------------------------------
// Load and restart transactions produce no result.
// A tick transaction walks a token through the row of MAX_TASKS slot cells,
// one cell per cycle, between a launch register and the result register.
// Busy is set when a tick is accepted and clears once the token leaves the
// last cell; no command is accepted while busy. Results cannot be stalled.
// Reset zeroes every phase, remaining budget and the active task count; slot
// parameters hold no value until loaded.
// ----------------------------------------------------------------------------
module deadline_monotonic_tick_scheduler import dmts_pkg::*; #(
    parameter int MAX_TASKS  = 8,
    parameter int TICK_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [IN_SLOT_W-1:0] i_slot,
    input  logic [FIELD_W-1:0]   i_budget,
    input  logic [FIELD_W-1:0]   i_period,
    input  logic [FIELD_W-1:0]   i_deadline,
    input  logic [ID_W-1:0]      i_task_id,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output logic                 o_valid,
    output logic                 o_busy_res,
    output logic [ID_W-1:0]      o_running_id,
    output logic [IN_SLOT_W-1:0] o_running_slot
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [CFG_W-1:0]     r_active_tasks;
    logic                 r_launch;
    logic                 r_valid;
    logic                 r_busy_res;
    logic [ID_W-1:0]      r_running_id;
    logic [IN_SLOT_W-1:0] r_running_slot;

    logic                  w_accept;
    logic                  w_load;
    logic                  w_restart;
    logic                  w_tick;
    logic                  w_fin;
    logic [TICK_WIDTH-1:0] w_budget;
    logic [TICK_WIDTH-1:0] w_period;
    logic [TICK_WIDTH-1:0] w_deadline;

    logic                  w_tok_vld      [0:MAX_TASKS];
    logic                  w_tok_found    [0:MAX_TASKS];
    logic [TICK_WIDTH-1:0] w_tok_deadline [0:MAX_TASKS];
    logic [SLOT_W-1:0]     w_tok_slot     [0:MAX_TASKS];
    logic [ID_W-1:0]       w_tok_id       [0:MAX_TASKS];

    assign busy       = (r_state != ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_load     = w_accept && (t_cmd'(i_command) == CMD_LOAD);
    assign w_restart  = w_accept && (t_cmd'(i_command) == CMD_RESTART);
    assign w_tick     = w_accept && (t_cmd'(i_command) == CMD_TICK);
    assign w_fin      = (r_state == ST_WALK) && w_tok_vld[MAX_TASKS];
    assign w_budget   = TICK_WIDTH'(i_budget);
    assign w_period   = TICK_WIDTH'(i_period);
    assign w_deadline = TICK_WIDTH'(i_deadline);

    assign w_tok_vld[0]      = r_launch;
    assign w_tok_found[0]    = 1'b0;
    assign w_tok_deadline[0] = '0;
    assign w_tok_slot[0]     = '0;
    assign w_tok_id[0]       = '0;

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        logic w_active;
        logic w_sel;

        assign w_active = (32'(r_active_tasks) > k);
        assign w_sel    = w_load && (32'(i_slot) == k);

        dmts_cell #(
            .TICK_WIDTH (TICK_WIDTH),
            .SLOT_W     (SLOT_W),
            .IDX        (k)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_active       (w_active),
            .i_load         (w_sel),
            .i_restart      (w_restart),
            .i_budget       (w_budget),
            .i_period       (w_period),
            .i_deadline     (w_deadline),
            .i_task_id      (i_task_id),
            .i_tok_vld      (w_tok_vld[k]),
            .i_tok_found    (w_tok_found[k]),
            .i_tok_deadline (w_tok_deadline[k]),
            .i_tok_slot     (w_tok_slot[k]),
            .i_tok_id       (w_tok_id[k]),
            .o_tok_vld      (w_tok_vld[k+1]),
            .o_tok_found    (w_tok_found[k+1]),
            .o_tok_deadline (w_tok_deadline[k+1]),
            .o_tok_slot     (w_tok_slot[k+1]),
            .o_tok_id       (w_tok_id[k+1]),
            .i_fin          (w_fin),
            .i_fin_found    (w_tok_found[MAX_TASKS]),
            .i_fin_slot     (w_tok_slot[MAX_TASKS])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_tick) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_active_tasks <= '0;
            r_launch       <= 1'b0;
            r_valid        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_tick;
            r_valid  <= w_fin;
            if (i_cfg_we) begin
                r_active_tasks <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_busy_res     <= w_tok_found[MAX_TASKS];
            r_running_id   <= w_tok_id[MAX_TASKS];
            r_running_slot <= IN_SLOT_W'(w_tok_slot[MAX_TASKS]);
        end
    end

    assign o_valid        = r_valid;
    assign o_busy_res     = r_busy_res;
    assign o_running_id   = r_running_id;
    assign o_running_slot = r_running_slot;

endmodule
